/* rtl/core/falling_sand_grid_step_unit_assert.svh */
// Assertion macros for the falling-sand grid step unit.
// Depends on nothing; included by the modules that check themselves.
`ifndef FALLING_SAND_GRID_STEP_UNIT_ASSERT_SVH
`define FALLING_SAND_GRID_STEP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, off while reset is asserted.
`define FSGS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check, active during reset too.
`define FSGS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSGS_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define FSGS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/core/fsgs_pkg.sv */
// Shared constants, codes and helpers for the falling-sand grid step unit.
// Depends on nothing.
package fsgs_pkg;

    // request codes
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_ADD  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // random source
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;
    localparam logic [15:0] SEED_RESET = 16'd44257;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_T_RD0 = 4'd2;
    localparam logic [3:0] ST_T_RD1 = 4'd3;
    localparam logic [3:0] ST_T_CAP = 4'd4;
    localparam logic [3:0] ST_T_RUN = 4'd5;
    localparam logic [3:0] ST_T_WB  = 4'd6;
    localparam logic [3:0] ST_T_WB0 = 4'd7;
    localparam logic [3:0] ST_A_CHK = 4'd8;
    localparam logic [3:0] ST_A_WR  = 4'd9;
    localparam logic [3:0] ST_R_OUT = 4'd10;

    typedef logic [3:0] t_state;

    // residue mod 3: base-4 digits are congruent to their sum
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] t;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[4]) + 3'(s[3:2]) + 3'(s[1:0]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

/* rtl/core/falling_sand_grid_step_unit.sv */
// Falling-sand grid step unit: row-wide occupancy memory and its sweep sequencer.
// Depends on fsgs_pkg and falling_sand_grid_step_unit_assert.svh.
//
// Usage: a request word is taken when start is high and busy is low. Each
// request gives exactly one result word on o_cell_value / o_accepted, shown
// for one cycle with o_done high; the receiver cannot stall it.
// A read out of range finishes without a memory access; in range it reads the
// row first. Add sand ends at its check when the cell is off the grid, else
// reads the row and writes it back with the cell set. In a tick sweep the grid
// is one row per memory word, the next row is read while the finished one is
// written back, and the sweep steps one column per cycle through the two row
// registers because each blocked grain draws from the LFSR in turn.
// Reset starts a clearing pass that writes one row per cycle over every row,
// with busy high; the seed register reloads to its reset value.
// The seed channel (i_cfg_valid / o_cfg_ready / i_cfg_data) is ready whenever
// reset is released and loads the LFSR directly; write it only while idle.
`include "falling_sand_grid_step_unit_assert.svh"

module falling_sand_grid_step_unit
    import fsgs_pkg::*;
#(
    parameter int GRID_COLS   = 128,
    parameter int GRID_ROWS   = 64,
    parameter int CELL_PIXELS = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic signed [11:0] i_pixel_x,
    input  logic signed [11:0] i_pixel_y,
    input  logic [6:0]         i_cell_col,
    input  logic [5:0]         i_cell_row,
    output logic               o_done,
    output logic               o_cell_value,
    output logic               o_accepted,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);

    localparam int COL_W = $clog2(GRID_COLS);
    localparam int ROW_W = $clog2(GRID_ROWS);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_COLS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);
    localparam logic [ROW_W-1:0] NEXT_ROW = ROW_W'(GRID_ROWS - 2);
    // reciprocal of the cell size, rounded up; exact for 11-bit dividends
    localparam int RECIP_SHIFT = 20;
    localparam logic [20:0] RECIP = 21'((2**RECIP_SHIFT + CELL_PIXELS - 1) / CELL_PIXELS);
    localparam logic signed [11:0] NEG_LIM = 12'(-CELL_PIXELS);

    // grid memory, one row per word
    logic [GRID_COLS-1:0] r_grid [GRID_ROWS];
    logic [GRID_COLS-1:0] r_rd_data;
    logic                 mem_we;
    logic [ROW_W-1:0]     mem_waddr;
    logic [GRID_COLS-1:0] mem_wdata;
    logic                 mem_re;
    logic [ROW_W-1:0]     mem_raddr;

    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_row, n_row;
    logic [15:0]      r_lfsr, n_lfsr;
    logic             r_done, n_done;
    logic             r_cell_value, n_cell_value;
    logic             r_accepted, n_accepted;

    logic [GRID_COLS-1:0] r_here, n_here;
    logic [GRID_COLS-1:0] r_below, n_below;
    logic [COL_W-1:0]     r_col, n_col;
    logic [10:0]          r_qx, n_qx;
    logic [10:0]          r_qy, n_qy;
    logic                 r_okx, n_okx;
    logic                 r_oky, n_oky;

    logic [31:0]      prod_x, prod_y;
    logic [15:0]      lfsr_nx;
    logic [1:0]       draw_mod;
    logic [COL_W-1:0] col_dn, col_up;

    assign prod_x   = 32'(i_pixel_x[10:0]) * 32'(RECIP);
    assign prod_y   = 32'(i_pixel_y[10:0]) * 32'(RECIP);
    assign lfsr_nx  = {1'b0, r_lfsr[15:1]} ^ (r_lfsr[0] ? LFSR_TAPS : 16'h0000);
    assign draw_mod = mod3_16(lfsr_nx);
    assign col_dn   = r_col - 1'b1;
    assign col_up   = r_col + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_lfsr       = r_lfsr;
        n_done       = 1'b0;
        n_cell_value = 1'b0;
        n_accepted   = 1'b0;
        n_here       = r_here;
        n_below      = r_below;
        n_col        = r_col;
        n_qx         = r_qx;
        n_qy         = r_qy;
        n_okx        = r_okx;
        n_oky        = r_oky;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (i_req_type)
                        REQ_TICK: begin
                            n_state = ST_T_RD0;
                        end
                        REQ_ADD: begin
                            // negative pixels above -CELL_PIXELS land in cell 0
                            n_okx   = !i_pixel_x[11] || (i_pixel_x > NEG_LIM);
                            n_oky   = !i_pixel_y[11] || (i_pixel_y > NEG_LIM);
                            n_qx    = i_pixel_x[11] ? 11'd0
                                                    : prod_x[RECIP_SHIFT+10:RECIP_SHIFT];
                            n_qy    = i_pixel_y[11] ? 11'd0
                                                    : prod_y[RECIP_SHIFT+10:RECIP_SHIFT];
                            n_state = ST_A_CHK;
                        end
                        REQ_READ: begin
                            if (int'(i_cell_col) < GRID_COLS &&
                                int'(i_cell_row) < GRID_ROWS) begin
                                mem_re    = 1'b1;
                                mem_raddr = ROW_W'(i_cell_row);
                                n_col     = COL_W'(i_cell_col);
                                n_state   = ST_R_OUT;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_row;
                if (r_row == LAST_ROW) begin
                    n_row   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            ST_T_RD0: begin
                mem_re    = 1'b1;
                mem_raddr = LAST_ROW;
                n_state   = ST_T_RD1;
            end
            ST_T_RD1: begin
                n_below   = r_rd_data;
                mem_re    = 1'b1;
                mem_raddr = NEXT_ROW;
                n_row     = NEXT_ROW;
                n_state   = ST_T_CAP;
            end
            ST_T_CAP: begin
                n_here  = r_rd_data;
                n_col   = '0;
                n_state = ST_T_RUN;
            end
            ST_T_RUN: begin
                if (r_here[r_col]) begin
                    if (!r_below[r_col]) begin
                        n_here[r_col]  = 1'b0;
                        n_below[r_col] = 1'b1;
                    end else begin
                        // blocked: draw, then try the diagonal
                        n_lfsr = lfsr_nx;
                        if (draw_mod == 2'd0 && r_col != '0 && !r_below[col_dn]) begin
                            n_here[r_col]   = 1'b0;
                            n_below[col_dn] = 1'b1;
                        end else if (draw_mod == 2'd2 && r_col != LAST_COL &&
                                     !r_below[col_up]) begin
                            n_here[r_col]   = 1'b0;
                            n_below[col_up] = 1'b1;
                        end
                    end
                end
                if (r_col == LAST_COL) begin
                    n_state = ST_T_WB;
                end else begin
                    n_col = col_up;
                end
            end
            ST_T_WB: begin
                // the lower row is final; retire it and slide the window up
                mem_we    = 1'b1;
                mem_waddr = r_row + 1'b1;
                mem_wdata = r_below;
                n_below   = r_here;
                if (r_row == '0) begin
                    n_state = ST_T_WB0;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_row - 1'b1;
                    n_row     = r_row - 1'b1;
                    n_state   = ST_T_CAP;
                end
            end
            ST_T_WB0: begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = r_below;
                n_done     = 1'b1;
                n_accepted = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_A_CHK: begin
                if (r_okx && r_oky && int'(r_qx) < GRID_COLS && int'(r_qy) < GRID_ROWS) begin
                    mem_re    = 1'b1;
                    mem_raddr = ROW_W'(r_qy);
                    n_row     = ROW_W'(r_qy);
                    n_col     = COL_W'(r_qx);
                    n_state   = ST_A_WR;
                end else begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_A_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_row;
                mem_wdata  = r_rd_data | ({{(GRID_COLS-1){1'b0}}, 1'b1} << r_col);
                n_row      = '0;
                n_done     = 1'b1;
                n_accepted = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_R_OUT: begin
                n_cell_value = r_rd_data[r_col];
                n_done       = 1'b1;
                n_accepted   = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            n_lfsr = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_grid[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_grid[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_row        <= '0;
            r_lfsr       <= SEED_RESET;
            r_done       <= 1'b0;
            r_cell_value <= 1'b0;
            r_accepted   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_row        <= n_row;
            r_lfsr       <= n_lfsr;
            r_done       <= n_done;
            r_cell_value <= n_cell_value;
            r_accepted   <= n_accepted;
        end
    end

    always_ff @(posedge i_clk) begin
        r_here  <= n_here;
        r_below <= n_below;
        r_col   <= n_col;
        r_qx    <= n_qx;
        r_qy    <= n_qy;
        r_okx   <= n_okx;
        r_oky   <= n_oky;
    end

    assign busy         = (r_state != ST_IDLE) || !i_rst_n;
    assign o_done       = r_done;
    assign o_cell_value = r_cell_value;
    assign o_accepted   = r_accepted;
    assign o_cfg_ready  = i_rst_n;

    `FSGS_ASSERT_RST(a_done_when_idle, i_clk, i_rst_n, o_done |-> !busy, "result shown while busy")
    `FSGS_ASSERT_ALWAYS(a_acc_needs_done, i_clk,
        (o_accepted || o_cell_value) |-> o_done, "result bits without strobe")
    `FSGS_ASSERT_RST(a_wb_after_last_col, i_clk, i_rst_n,
        (r_state == ST_T_WB) |-> ($past(r_state) == ST_T_RUN && $past(r_col) == LAST_COL),
        "row retired before its last column")
    `FSGS_ASSERT_RST(a_tick_goes_busy, i_clk, i_rst_n,
        (start && !busy && i_req_type == REQ_TICK) |=> busy, "tick taken without starting sweep")

endmodule
